// ----- src/ihex_pkg.sv -----
// Shared types, constants and character helpers of the Intel HEX record encoder.
package ihex_pkg;

    localparam logic [15:0] ORIGIN_RESET = 16'h0100;
    localparam int          TERM_LEN     = 12;
    localparam int          HDR_PAIRS    = 4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       carries_byte;
        logic       end_of_stream;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] hex_char;
        logic       run_last;
    } out_beat_t;

    typedef enum logic [2:0] {
        CH_COLON,
        CH_HI,
        CH_LO,
        CH_NL,
        CH_TERM
    } char_kind_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        char_kind_t kind;
        logic       last;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic load_fills;
        logic load_nonempty;
        logic pair_last;
        logic term_last;
    } dp_sts_t;

    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'd0, nib};
        end else begin
            return 8'h37 + {4'd0, nib};
        end
    endfunction

    function automatic logic [7:0] term_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h3A;
            4'd11:   c = 8'h0A;
            default: c = 8'h30;
        endcase
        return c;
    endfunction

endpackage

// ----- src/ihex_dp.sv -----
// Datapath of the Intel HEX record encoder: record buffer, addresses, checksum, output register.
module ihex_dp #(
    parameter int RECORD_BYTES = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ihex_pkg::in_beat_t s_data,
    input  logic               m_ready,
    output logic               m_valid,
    output ihex_pkg::out_beat_t m_data,
    input  logic               cfg_wr_en,
    input  logic [15:0]        cfg_wr_data,
    input  ihex_pkg::dp_cmd_t  cmd,
    output ihex_pkg::dp_sts_t  sts
);
    import ihex_pkg::*;

    localparam int IDX_W  = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
    localparam int DEPTH  = 2 ** IDX_W;
    localparam int CNT_W  = $clog2(RECORD_BYTES + 1);
    localparam int PIDX_W = $clog2(RECORD_BYTES + HDR_PAIRS + 1);
    localparam int TIDX_W = $clog2(TERM_LEN);

    logic [7:0]        buf_reg [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [15:0]       origin_reg;
    logic [15:0]       next_addr_reg;
    logic [15:0]       rec_addr_reg;
    logic              in_stream_reg;
    logic [PIDX_W-1:0] pidx_reg;
    logic [7:0]        sum_reg;
    logic [TIDX_W-1:0] tidx_reg;
    logic              m_valid_reg;
    out_beat_t         m_data_reg;

    logic [PIDX_W-1:0] last_pidx;
    logic [PIDX_W-1:0] data_pidx;
    logic [7:0]        sel_byte;
    logic [7:0]        char_next;

    assign last_pidx = PIDX_W'(HDR_PAIRS) + PIDX_W'(count_reg);
    assign data_pidx = pidx_reg - PIDX_W'(HDR_PAIRS);

    always_comb begin
        if (pidx_reg == PIDX_W'(0)) begin
            sel_byte = 8'(count_reg);
        end else if (pidx_reg == PIDX_W'(1)) begin
            sel_byte = rec_addr_reg[15:8];
        end else if (pidx_reg == PIDX_W'(2)) begin
            sel_byte = rec_addr_reg[7:0];
        end else if (pidx_reg == PIDX_W'(3)) begin
            sel_byte = 8'h00;
        end else if (pidx_reg == last_pidx) begin
            sel_byte = 8'h00 - sum_reg;
        end else begin
            sel_byte = buf_reg[data_pidx[IDX_W-1:0]];
        end
    end

    always_comb begin
        case (cmd.kind)
            CH_COLON: char_next = 8'h3A;
            CH_HI:    char_next = hex_ascii(sel_byte[7:4]);
            CH_LO:    char_next = hex_ascii(sel_byte[3:0]);
            CH_NL:    char_next = 8'h0A;
            CH_TERM:  char_next = term_char(4'(tidx_reg));
            default:  char_next = 8'h00;
        endcase
    end

    assign sts.out_free      = !m_valid_reg || m_ready;
    assign sts.load_fills    = s_data.carries_byte && (count_reg == CNT_W'(RECORD_BYTES - 1));
    assign sts.load_nonempty = s_data.carries_byte || (count_reg != CNT_W'(0));
    assign sts.pair_last     = (pidx_reg == last_pidx);
    assign sts.term_last     = (tidx_reg == TIDX_W'(TERM_LEN - 1));

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load && s_data.carries_byte) begin
            buf_reg[count_reg[IDX_W-1:0]] <= s_data.data_byte;
        end
        if (cmd.emit) begin
            m_data_reg.hex_char <= char_next;
            m_data_reg.run_last <= cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            origin_reg    <= ORIGIN_RESET;
            next_addr_reg <= ORIGIN_RESET;
            rec_addr_reg  <= ORIGIN_RESET;
            in_stream_reg <= 1'b0;
            pidx_reg      <= '0;
            sum_reg       <= '0;
            tidx_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                origin_reg <= cfg_wr_data;
                if (!in_stream_reg) begin
                    next_addr_reg <= cfg_wr_data;
                end
            end
            if (cmd.load && s_data.carries_byte) begin
                if (count_reg == CNT_W'(0)) begin
                    rec_addr_reg <= next_addr_reg;
                end
                count_reg     <= count_reg + CNT_W'(1);
                next_addr_reg <= next_addr_reg + 16'd1;
                in_stream_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
                case (cmd.kind)
                    CH_COLON: begin
                        pidx_reg <= '0;
                        sum_reg  <= '0;
                    end
                    CH_LO: begin
                        sum_reg  <= sum_reg + sel_byte;
                        pidx_reg <= pidx_reg + PIDX_W'(1);
                    end
                    CH_NL: begin
                        count_reg <= '0;
                        pidx_reg  <= '0;
                    end
                    CH_TERM: begin
                        if (sts.term_last) begin
                            tidx_reg      <= '0;
                            count_reg     <= '0;
                            next_addr_reg <= origin_reg;
                            in_stream_reg <= 1'b0;
                        end else begin
                            tidx_reg <= tidx_reg + TIDX_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ----- src/ihex_ctrl.sv -----
// Controller state machine of the Intel HEX record encoder.
module ihex_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ihex_pkg::in_beat_t s_data,
    input  ihex_pkg::dp_sts_t sts,
    output ihex_pkg::dp_cmd_t cmd
);
    import ihex_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COLON,
        ST_HI,
        ST_LO,
        ST_NL,
        ST_TERM
    } state_t;

    state_t state_reg;
    logic   term_pend_reg;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.load = 1'b0;
        cmd.emit = 1'b0;
        cmd.kind = CH_COLON;
        cmd.last = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load = s_valid;
            end
            ST_COLON: begin
                cmd.emit = sts.out_free;
                cmd.kind = CH_COLON;
            end
            ST_HI: begin
                cmd.emit = sts.out_free;
                cmd.kind = CH_HI;
            end
            ST_LO: begin
                cmd.emit = sts.out_free;
                cmd.kind = CH_LO;
            end
            ST_NL: begin
                cmd.emit = sts.out_free;
                cmd.kind = CH_NL;
                cmd.last = !term_pend_reg;
            end
            ST_TERM: begin
                cmd.emit = sts.out_free;
                cmd.kind = CH_TERM;
                cmd.last = sts.term_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            term_pend_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        term_pend_reg <= s_data.end_of_stream;
                        if (sts.load_fills) begin
                            state_reg <= ST_COLON;
                        end else if (s_data.end_of_stream && sts.load_nonempty) begin
                            state_reg <= ST_COLON;
                        end else if (s_data.end_of_stream) begin
                            state_reg <= ST_TERM;
                        end
                    end
                end
                ST_COLON: begin
                    if (sts.out_free) begin
                        state_reg <= ST_HI;
                    end
                end
                ST_HI: begin
                    if (sts.out_free) begin
                        state_reg <= ST_LO;
                    end
                end
                ST_LO: begin
                    if (sts.out_free) begin
                        state_reg <= sts.pair_last ? ST_NL : ST_HI;
                    end
                end
                ST_NL: begin
                    if (sts.out_free) begin
                        state_reg <= term_pend_reg ? ST_TERM : ST_IDLE;
                    end
                end
                ST_TERM: begin
                    if (sts.out_free && sts.term_last) begin
                        state_reg     <= ST_IDLE;
                        term_pend_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- src/intel_hex_record_encoder.sv -----
// Top level of the Intel HEX record encoder: controller plus datapath.
//
// Input beats (s_*) carry one binary byte, a flag telling whether the byte
// is present, and an end-of-stream mark. Output beats (m_*) carry one ASCII
// character of Intel HEX text; run_last marks the final character caused by
// an input beat. cfg_wr_en/cfg_wr_data load the origin address; write it only
// while the block is idle.
// Input beats are accepted only while the controller is idle. A beat that
// completes a record of RECORD_BYTES bytes, or ends the stream, is followed
// by its characters at one per cycle while the receiver takes them:
// 1 + 2*(5 + n) + 1 for a record of n bytes, plus 12 for the terminator.
// Acceptance sets the state register, and then the output register takes
// the first character. s_ready stays low until the last character is in the
// output register. Reset clears the buffer count and loads the origin and
// load address with 0x0100. When the receiver stalls, the output register
// holds its character and the controller holds its place.
module intel_hex_record_encoder #(
    parameter int RECORD_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ihex_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ihex_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import ihex_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    ihex_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    ihex_dp #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

`ifndef NO_ASSERTIONS
    a_emit_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> !s_ready)
        else $error("character emitted while accepting beats");

    a_emit_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("output register overwritten");

    a_load_handshake: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (s_valid && s_ready))
        else $error("buffer load without an accepted beat");

    a_term_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && cmd.kind == CH_TERM && sts.term_last) |=> (s_ready && m_data.run_last))
        else $error("terminator did not return to idle");
`endif

endmodule
